// File: rtl/ott_pkg.sv
// Shared types and constants for the ordered timer table.
`timescale 1ns / 1ps
package ott_pkg;
   localparam int Capacity = 16;
   localparam int IdxW = $clog2(Capacity);
   localparam int MaxOut = 16;

   typedef enum logic [1:0] {
      ACT_ADD  = 2'd0,
      ACT_DEL  = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_DELETED  = 3'd2,
      KIND_NOTFOUND = 3'd3,
      KIND_EXPIRED  = 3'd4,
      KIND_NONE     = 3'd5
   } kind_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [39:0] now_ms;
      logic [30:0] delay_ms;
      logic [31:0] del_id;
      logic [39:0] del_expire;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] timer_id;
      logic [39:0] expire_time;
      logic        last;
      logic        pending_any;
      logic [39:0] next_expire;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      action_type  action;
      logic [39:0] now_ms;
      logic [39:0] key_expire;
      logic [31:0] key_id;
   } cmd_type;
endpackage

// File: rtl/ott_front.sv
// Front end: accepts requests, computes saturated expiry, queues commands.
`timescale 1ns / 1ps
module ott_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ott_pkg::req_type  req_item,
   output logic              cmd_valid,
   output ott_pkg::cmd_type  cmd_item,
   input  logic              cmd_pop,
   input  logic [31:0]       next_ident
);
   import ott_pkg::*;

   // Two-entry queue; the back end is strictly serial so one item is in flight.
   cmd_type     q_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ff, rd_in, wr_ff, wr_in;
   logic        push;
   logic [40:0] sum;
   cmd_type     cmd_new;

   assign busy      = (count_ff != 2'd0);
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_item  = q_ff[rd_ff];

   always_comb begin
      sum = {1'b0, req_item.now_ms} + {10'd0, req_item.delay_ms};
      cmd_new.action = action_type'(req_item.action);
      cmd_new.now_ms = req_item.now_ms;
      if (req_item.action == ACT_DEL) begin
         cmd_new.key_expire = req_item.del_expire;
         cmd_new.key_id     = req_item.del_id;
      end else begin
         cmd_new.key_expire = sum[40] ? {40{1'b1}} : sum[39:0];
         cmd_new.key_id     = next_ident;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, cmd_pop};
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = cmd_pop ? !rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cmd_new;
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end
endmodule

// File: rtl/ott_back.sv
// Back end: scans the timer table one entry a cycle and emits results.
`timescale 1ns / 1ps
module ott_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  ott_pkg::cmd_type  cmd_item,
   output logic              cmd_pop,
   output logic [31:0]       next_ident,
   output logic              rsp_strobe,
   output ott_pkg::rsp_type  rsp_item
);
   import ott_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_EMIT
   } state_type;

   state_type   state_ff;
   logic        valid_ff [Capacity];
   logic [39:0] exp_ff   [Capacity];
   logic [31:0] id_ff    [Capacity];
   logic [IdxW-1:0] idx_ff;
   logic        rescan_ff;
   logic [31:0] ident_ff;
   // Scan results
   logic        match_ff, free_ff, min_ok_ff;
   logic [IdxW-1:0] match_at_ff, free_at_ff, min_at_ff;
   logic [39:0] min_exp_ff;
   logic [31:0] min_id_ff;
   logic [4:0]  emitted_ff;
   // Result held between update and rescan
   kind_type    kind_ff;
   logic [31:0] out_id_ff;
   logic [39:0] out_exp_ff;
   logic        strobe_ff;
   rsp_type     rsp_ff;

   logic        better;
   logic        due;
   logic        more;

   assign next_ident = ident_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
   assign better = valid_ff[idx_ff] && (!min_ok_ff || exp_ff[idx_ff] < min_exp_ff ||
                   (exp_ff[idx_ff] == min_exp_ff && id_ff[idx_ff] < min_id_ff));
   assign due    = min_ok_ff && (min_exp_ff <= cmd_item.now_ms);
   // another expiry follows this one within the same tick
   assign more   = (kind_ff == KIND_EXPIRED) && due && (emitted_ff != 5'(MaxOut));
   assign cmd_pop = (state_ff == ST_EMIT) && !more;

   always_ff @(posedge clock) begin
      strobe_ff <= !reset && (state_ff == ST_EMIT);
      if (reset) begin
         state_ff   <= ST_IDLE;
         ident_ff   <= '0;
         emitted_ff <= '0;
         for (int k = 0; k < Capacity; k++) valid_ff[k] <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  state_ff   <= ST_SCAN;
                  idx_ff     <= '0;
                  rescan_ff  <= 1'b0;
                  match_ff   <= 1'b0;
                  free_ff    <= 1'b0;
                  min_ok_ff  <= 1'b0;
                  emitted_ff <= '0;
               end
            end
            ST_SCAN: begin
               if (valid_ff[idx_ff] && id_ff[idx_ff] == cmd_item.key_id &&
                   exp_ff[idx_ff] == cmd_item.key_expire && !match_ff) begin
                  match_ff    <= 1'b1;
                  match_at_ff <= idx_ff;
               end
               if (!valid_ff[idx_ff] && !free_ff) begin
                  free_ff    <= 1'b1;
                  free_at_ff <= idx_ff;
               end
               if (better) begin
                  min_ok_ff  <= 1'b1;
                  min_at_ff  <= idx_ff;
                  min_exp_ff <= exp_ff[idx_ff];
                  min_id_ff  <= id_ff[idx_ff];
               end
               if (idx_ff == IdxW'(Capacity - 1))
                  state_ff <= rescan_ff ? ST_EMIT : ST_APPLY;
               idx_ff <= idx_ff + 1'b1;
            end
            ST_APPLY: begin
               case (cmd_item.action)
                  ACT_ADD: begin
                     if (match_ff || free_ff) begin
                        kind_ff    <= KIND_ADDED;
                        out_id_ff  <= cmd_item.key_id;
                        out_exp_ff <= cmd_item.key_expire;
                        ident_ff   <= ident_ff + 32'd1;
                        // a duplicate of a pending timer is reported, not inserted
                        if (!match_ff) begin
                           valid_ff[free_at_ff] <= 1'b1;
                           exp_ff[free_at_ff]   <= cmd_item.key_expire;
                           id_ff[free_at_ff]    <= cmd_item.key_id;
                        end
                     end else begin
                        kind_ff    <= KIND_FULL;
                        out_id_ff  <= '0;
                        out_exp_ff <= '0;
                     end
                  end
                  ACT_DEL: begin
                     kind_ff    <= match_ff ? KIND_DELETED : KIND_NOTFOUND;
                     out_id_ff  <= cmd_item.key_id;
                     out_exp_ff <= cmd_item.key_expire;
                     if (match_ff) valid_ff[match_at_ff] <= 1'b0;
                  end
                  ACT_TICK: begin
                     if (due) begin
                        kind_ff    <= KIND_EXPIRED;
                        out_id_ff  <= min_id_ff;
                        out_exp_ff <= min_exp_ff;
                        valid_ff[min_at_ff] <= 1'b0;
                        emitted_ff <= emitted_ff + 5'd1;
                     end else begin
                        kind_ff    <= KIND_NONE;
                        out_id_ff  <= '0;
                        out_exp_ff <= '0;
                     end
                  end
                  default: begin
                     kind_ff    <= KIND_NONE;
                     out_id_ff  <= '0;
                     out_exp_ff <= '0;
                  end
               endcase
               // rescan to find the earliest timer left after the update
               state_ff  <= ST_SCAN;
               idx_ff    <= '0;
               rescan_ff <= 1'b1;
               match_ff  <= 1'b0;
               free_ff   <= 1'b0;
               min_ok_ff <= 1'b0;
            end
            ST_EMIT: begin
               rsp_ff.kind        <= kind_ff;
               rsp_ff.timer_id    <= out_id_ff;
               rsp_ff.expire_time <= out_exp_ff;
               rsp_ff.last        <= !more;
               rsp_ff.pending_any <= min_ok_ff;
               rsp_ff.next_expire <= min_ok_ff ? min_exp_ff : '0;
               // rescan minimum is the next expiry candidate
               state_ff <= more ? ST_APPLY : ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/ordered_timer_table.sv
// Top level of the ordered timer table.
// A one-result item gives its result after a scan, the update and a rescan of the table.
// A tick gives up to 16 results; each expiry after the first follows another update and rescan.
// One item in flight; busy drops while the final result is shown, so a new item is
// accepted only once the previous one has given its final result. Results cannot be stalled.
// Synchronous reset clears all valid bits and the id counter at once.
`timescale 1ns / 1ps
module ordered_timer_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ott_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ott_pkg::rsp_type rsp_item
);
   import ott_pkg::*;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_item;
   logic [31:0] next_ident;

   ott_front u_front (.clock, .reset, .start, .busy, .req_item, .cmd_valid,
      .cmd_item, .cmd_pop, .next_ident);
   ott_back u_back (.clock, .reset, .cmd_valid, .cmd_item, .cmd_pop, .next_ident,
      .rsp_strobe, .rsp_item);
endmodule

// Port checks for the ordered timer table.
module ott_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input ott_pkg::rsp_type rsp_item
);
   import ott_pkg::*;

   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({busy, rsp_strobe}))
      else $error("busy or rsp_strobe unknown");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after an item was accepted");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("rsp_strobe high on two cycles in a row");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.kind <= KIND_NONE)
      else $error("result kind out of range");

   a_next_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.pending_any |-> rsp_item.next_expire == '0)
      else $error("next_expire nonzero with nothing pending");
endmodule

bind ordered_timer_table ott_checker u_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_item
);

// File: sim/tb.sv
// Testbench for the ordered timer table: randomized commands checked against a table model.
`timescale 1ns / 1ps
module tb;
   import ott_pkg::*;

   localparam int Cap = 16;
   localparam int IdleLimit = 4000;
   localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   ordered_timer_table u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // model of the timer table
   logic        tbl_valid [Cap];
   logic [39:0] tbl_expire [Cap];
   logic [31:0] tbl_id [Cap];
   logic [31:0] id_counter;

   req_type cmd_queue [$];
   rsp_type expected_rsps [$];
   // recently issued timers, used to aim deletes at real entries
   logic [31:0] known_ids [$];
   logic [39:0] known_exps [$];

   int  errors = 0;
   int  idle_cycles = 0;
   int  gap = 0;
   bit  stim_done = 0;
   // accepted flag: set by the rising edge that takes the item
   bit  busy_seen = 1;

   function automatic int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < Cap; i++) begin
         if (tbl_valid[i]) begin
            if (best < 0 || tbl_expire[i] < tbl_expire[best] ||
                (tbl_expire[i] == tbl_expire[best] && tbl_id[i] < tbl_id[best]))
               best = i;
         end
      end
      return best;
   endfunction

   function automatic int match_slot(logic [31:0] id, logic [39:0] exp);
      for (int i = 0; i < Cap; i++)
         if (tbl_valid[i] && tbl_id[i] == id && tbl_expire[i] == exp) return i;
      return -1;
   endfunction

   function automatic void push_rsp(kind_type k, logic [31:0] id, logic [39:0] exp);
      rsp_type r;
      int m;
      m = earliest_slot();
      r.kind = k;
      r.timer_id = id;
      r.expire_time = exp;
      r.last = 1'b0;
      r.pending_any = (m >= 0);
      r.next_expire = (m >= 0) ? tbl_expire[m] : 40'd0;
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_timer_cmd(req_type c);
      logic [40:0] sum;
      logic [39:0] exp;
      logic [31:0] id;
      int slot, m, n;
      n = 0;
      case (action_type'(c.action))
         ACT_ADD: begin
            sum = {1'b0, c.now_ms} + {10'd0, c.delay_ms};
            exp = sum[40] ? Max40 : sum[39:0];
            id = id_counter;
            if (match_slot(id, exp) >= 0) begin
               id_counter++;
               push_rsp(KIND_ADDED, id, exp);
            end else begin
               slot = -1;
               for (int i = 0; i < Cap; i++)
                  if (!tbl_valid[i] && slot < 0) slot = i;
               if (slot < 0) push_rsp(KIND_FULL, 32'd0, 40'd0);
               else begin
                  id_counter++;
                  tbl_valid[slot] = 1'b1;
                  tbl_expire[slot] = exp;
                  tbl_id[slot] = id;
                  known_ids.push_back(id);
                  known_exps.push_back(exp);
                  push_rsp(KIND_ADDED, id, exp);
               end
            end
         end
         ACT_DEL: begin
            m = match_slot(c.del_id, c.del_expire);
            if (m >= 0) begin
               tbl_valid[m] = 1'b0;
               push_rsp(KIND_DELETED, c.del_id, c.del_expire);
            end else begin
               push_rsp(KIND_NOTFOUND, c.del_id, c.del_expire);
            end
         end
         ACT_TICK: begin
            while (n < MaxOut) begin
               m = earliest_slot();
               if (m < 0 || tbl_expire[m] > c.now_ms) break;
               tbl_valid[m] = 1'b0;
               push_rsp(KIND_EXPIRED, tbl_id[m], tbl_expire[m]);
               n++;
            end
            if (n == 0) push_rsp(KIND_NONE, 32'd0, 40'd0);
         end
         default: push_rsp(KIND_NONE, 32'd0, 40'd0);
      endcase
      expected_rsps[$].last = 1'b1;
   endfunction

   function automatic req_type make_cmd(logic [1:0] act, logic [39:0] now,
                                        logic [30:0] dly, logic [31:0] did,
                                        logic [39:0] dexp);
      req_type c;
      c.action = act;
      c.now_ms = now;
      c.delay_ms = dly;
      c.del_id = did;
      c.del_expire = dexp;
      return c;
   endfunction

   function automatic logic [39:0] rand40();
      return {8'($urandom_range(255, 0)), $urandom()};
   endfunction

   // time base keeps adds and ticks interacting
   logic [39:0] clock_ms = 40'd1000;

   initial begin
      int k;
      req_type c;
      for (int i = 0; i < Cap; i++) tbl_valid[i] = 1'b0;
      id_counter = '0;
      // directed: extremes, full table, saturation, wrap-free duplicates, misses
      cmd_queue.push_back(make_cmd(ACT_TICK, 40'd0, '0, '0, '0));
      cmd_queue.push_back(make_cmd(ACT_ADD, Max40, 31'h7FFF_FFFF, '0, '0));
      cmd_queue.push_back(make_cmd(ACT_ADD, 40'd0, 31'd0, '0, '0));
      cmd_queue.push_back(make_cmd(ACT_DEL, '0, '0, 32'hFFFF_FFFF, Max40));
      cmd_queue.push_back(make_cmd(ACT_DEL, '0, '0, 32'd0, Max40));
      cmd_queue.push_back(make_cmd(ACT_NOP, Max40, 31'h7FFF_FFFF, '1, '1));
      for (int i = 0; i < 16; i++)
         cmd_queue.push_back(make_cmd(ACT_ADD, 40'd100, 31'(i % 3), '0, '0));
      cmd_queue.push_back(make_cmd(ACT_TICK, 40'd50, '0, '0, '0));
      cmd_queue.push_back(make_cmd(ACT_TICK, Max40, '0, '0, '0));
      cmd_queue.push_back(make_cmd(ACT_TICK, Max40, '0, '0, '0));
      // random phase
      for (int i = 0; i < 85; i++) begin
         k = $urandom_range(99, 0);
         clock_ms = clock_ms + 40'($urandom_range(200, 0));
         if (k < 45)
            c = make_cmd(ACT_ADD, ($urandom_range(19, 0) == 0) ? rand40() : clock_ms,
                         ($urandom_range(9, 0) == 0) ? 31'($urandom())
                                                     : 31'($urandom_range(600, 0)),
                         $urandom(), rand40());
         else if (k < 65)
            c = make_cmd(ACT_DEL, rand40(), 31'($urandom()), $urandom(), rand40());
         else if (k < 95)
            c = make_cmd(ACT_TICK, ($urandom_range(19, 0) == 0) ? rand40() : clock_ms,
                         31'($urandom()), $urandom(), rand40());
         else
            c = make_cmd(ACT_NOP, rand40(), 31'($urandom()), $urandom(), rand40());
         cmd_queue.push_back(c);
      end
      stim_done = 1;
   end

   // driver: deletes of live timers are patched in at issue time
   always @(negedge clock) begin
      req_type c;
      int p;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_seen) begin
         // held until accepted
      end else if (gap > 0) begin
         start <= 1'b0;
         gap <= gap - 1;
      end else if (cmd_queue.size() > 0) begin
         c = cmd_queue.pop_front();
         if (c.action == ACT_DEL && known_ids.size() > 0 && $urandom_range(2, 0) != 0) begin
            p = $urandom_range(known_ids.size() - 1, 0);
            c.del_id = known_ids[p];
            c.del_expire = known_exps[p];
            if ($urandom_range(4, 0) == 0) c.del_expire = c.del_expire ^ 40'd1;
         end
         req_item <= c;
         start <= 1'b1;
         gap <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(15, 0);
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) busy_seen <= 1;
      else if (start && !busy) begin
         busy_seen <= 1;
         predict_timer_cmd(req_item);
      end else if (start) busy_seen <= 0;
      else busy_seen <= 1;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_item);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_item !== e) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e, rsp_item);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && cmd_queue.size() == 0 && !start && expected_rsps.size() == 0))
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IdleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end
endmodule
